// ----- rtl/core/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types for the key/value table: command and result beats, the
// request token that walks the row of cells, and the stored pair.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ECNT_W  = 5;

  typedef enum logic [1:0] {
    ACT_PUT = 2'd0,
    ACT_DEL = 2'd1,
    ACT_GET = 2'd2,
    ACT_NOP = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic              status;
    logic              found;
    logic [VAL_W-1:0]  read_value;
    logic [ECNT_W-1:0] entry_count;
  } out_beat_t;

  // request walking down the row, one cell per cycle
  typedef struct packed {
    logic             vld;
    action_t          action;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             found;
    logic [VAL_W-1:0] rd;
  } token_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } pair_t;

endpackage

// ----- rtl/core/kvt_cell.sv -----
// ----------------------------------------------------------------------------
// kvt_cell
// One slot of the table. Compares the passing token against its pair,
// updates, inserts or shifts in its neighbor's pair, and hands the token on.
// ----------------------------------------------------------------------------
module kvt_cell
  import kvt_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5,
  parameter bit          LAST  = 1'b0
) (
  input  logic             clk,
  input  logic             rst,
  input  token_t           tok_in,
  input  logic [CNT_W-1:0] count,
  input  pair_t            nbr,
  output token_t           tok_out,
  output pair_t            entry
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  pair_t  entry_next;
  logic   we;
  token_t tok_next;
  logic   live;
  logic   hit;

  assign live = (IDX < count);
  assign hit  = tok_in.vld && live && !tok_in.found && (entry.key == tok_in.key);

  always_comb begin
    tok_next   = tok_in;
    entry_next = entry;
    we         = 1'b0;
    if (tok_in.vld) begin
      case (tok_in.action)
        ACT_PUT: begin
          if (hit) begin
            tok_next.found   = 1'b1;
            entry_next.value = tok_in.value;
            we               = 1'b1;
          end else if (!tok_in.found && IDX == count) begin
            entry_next.key   = tok_in.key;
            entry_next.value = tok_in.value;
            we               = 1'b1;
          end
        end
        ACT_DEL: begin
          // from the hole onward every live slot but the last pulls in its neighbor
          if (hit || (tok_in.found && live)) begin
            tok_next.found = 1'b1;
            if (!LAST) begin
              entry_next = nbr;
              we         = 1'b1;
            end
          end
        end
        ACT_GET: begin
          if (hit) begin
            tok_next.found = 1'b1;
            tok_next.rd    = entry.value;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
    if (we) begin
      entry <= entry_next;
    end
  end

endmodule

// ----- rtl/core/key_value_table.sv -----
// ----------------------------------------------------------------------------
// key_value_table
// Small associative table of key/value pairs held in a row of cells.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. The request then
// walks the row of CAPACITY cells, one cell per clock, and the result beat
// appears on rsp with done high for one cycle, registered from the token that
// leaves the last cell; busy drops in that same cycle, so a new command can be
// taken at the edge that ends it and no earlier. The receiver cannot stall:
// rsp must be captured while done is high. A delete closes the hole by
// shifting the later pairs down one slot as the request passes. entry_count is
// 5 bits wide, so CAPACITY is meant to stay at 31 or below for that field to
// be exact.
module key_value_table
  import kvt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_beat_t  cmd,
  output logic      busy,
  output logic      done,
  output out_beat_t rsp
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  token_t           tok_in  [CAPACITY];
  token_t           tok_out [CAPACITY];
  pair_t            entry   [CAPACITY];
  pair_t            nbr     [CAPACITY];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  token_t           head;
  token_t           fin;
  logic             accept;
  logic             put_miss;

  assign accept = start && !busy;

  always_comb begin
    head        = '0;
    head.vld    = accept;
    head.action = action_t'(cmd.action);
    head.key    = cmd.key;
    head.value  = cmd.value;
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign tok_in[i] = head;
      end else begin : g_mid
        assign tok_in[i] = tok_out[i-1];
      end
      if (i == CAPACITY - 1) begin : g_end
        assign nbr[i] = entry[i];
      end else begin : g_inner
        assign nbr[i] = entry[i+1];
      end
      kvt_cell #(
        .INDEX (i),
        .CNT_W (CNT_W),
        .LAST  (i == CAPACITY - 1)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (tok_in[i]),
        .count   (count),
        .nbr     (nbr[i]),
        .tok_out (tok_out[i]),
        .entry   (entry[i])
      );
    end
  endgenerate

  assign fin      = tok_out[CAPACITY-1];
  assign put_miss = (fin.action == ACT_PUT) && !fin.found;

  always_comb begin
    count_next = count;
    if (put_miss && count < CAP_C) begin
      count_next = count + 1'b1;
    end else if (fin.action == ACT_DEL && fin.found) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= fin.vld;
      if (accept) begin
        busy <= 1'b1;
      end else if (fin.vld) begin
        busy <= 1'b0;
      end
      if (fin.vld) begin
        count <= count_next;
      end
    end
    if (fin.vld) begin
      rsp.status      <= put_miss && (count == CAP_C);
      rsp.found       <= fin.found;
      rsp.read_value  <= (fin.action == ACT_GET && fin.found) ? fin.rd : '0;
      rsp.entry_count <= ECNT_W'(count_next);
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result beat while still busy");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("busy not raised after command beat");

  a_single_done : assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("two result beats back to back");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C) else $error("entry count above capacity");

  a_full_miss : assert property (@(posedge clk) disable iff (rst)
    done && rsp.status |-> !rsp.found) else $error("full status on a found key");
`endif

endmodule

// ----- bench/key_value_table_tb.sv -----
// ----------------------------------------------------------------------------
// key_value_table_tb
// Drives put, delete and get commands into the key/value table and checks
// every result beat against a scoreboard that keeps its own copy of the table.
// A short directed run covers the empty and full table, updates, deletes of
// the first and last slot and the unused action; random runs with a small key
// pool follow, with and without random gaps between command beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module key_value_table_tb;
  import kvt_pkg::*;

  localparam int unsigned TBL_DEPTH   = 16;
  localparam int unsigned KEY_POOL    = 24;
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  in_beat_t  cmd;
  logic      busy;
  logic      done;
  out_beat_t rsp;

  // scoreboard copy of the table
  logic [KEY_W-1:0] tbl_keys [TBL_DEPTH];
  logic [VAL_W-1:0] tbl_vals [TBL_DEPTH];
  int unsigned      tbl_count;

  out_beat_t        rsp_expected_q [$];
  out_beat_t        want_rsp;
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  int unsigned      mismatches = 0;
  int unsigned      cycle_cnt = 0;
  bit               idle_on = 1'b1;

  key_value_table #(
    .CAPACITY(TBL_DEPTH)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("key_value_table_tb NOT OK");
      $finish;
    end
  end

  // applies one command to the scoreboard table and returns its result beat
  function automatic out_beat_t table_apply(input in_beat_t b);
    out_beat_t r;
    int        slot;
    r = '0;
    slot = -1;
    if (action_t'(b.action) != ACT_NOP) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (slot < 0 && tbl_keys[i] == b.key) slot = i;
      end
    end
    r.found = (slot >= 0);
    case (action_t'(b.action))
      ACT_PUT: begin
        if (slot >= 0) begin
          tbl_vals[slot] = b.value;
        end else if (tbl_count < TBL_DEPTH) begin
          tbl_keys[tbl_count] = b.key;
          tbl_vals[tbl_count] = b.value;
          tbl_count++;
        end else begin
          r.status = 1'b1;
        end
      end
      ACT_DEL: begin
        if (slot >= 0) begin
          tbl_count--;
          tbl_keys[slot] = tbl_keys[tbl_count];
          tbl_vals[slot] = tbl_vals[tbl_count];
        end
      end
      ACT_GET: begin
        if (slot >= 0) r.read_value = tbl_vals[slot];
      end
      default: ;
    endcase
    r.entry_count = tbl_count[ECNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_cnt);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (rsp_expected_q.size() == 0) begin
        report_mismatch("unexpected result beat", rsp.read_value, '0);
      end else begin
        want_rsp = rsp_expected_q.pop_front();
        if (rsp.status !== want_rsp.status)
          report_mismatch("status", 32'(rsp.status), 32'(want_rsp.status));
        if (rsp.found !== want_rsp.found)
          report_mismatch("found", 32'(rsp.found), 32'(want_rsp.found));
        if (rsp.read_value !== want_rsp.read_value)
          report_mismatch("read_value", rsp.read_value, want_rsp.read_value);
        if (rsp.entry_count !== want_rsp.entry_count)
          report_mismatch("entry_count", 32'(rsp.entry_count),
                          32'(want_rsp.entry_count));
      end
    end
  end

  // one command beat: optional gap, then hold start until busy is low
  task automatic send_cmd(input action_t act, input logic [KEY_W-1:0] key,
                          input logic [VAL_W-1:0] value);
    in_beat_t b;
    b.action = act;
    b.key    = key;
    b.value  = value;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 99) < 11) begin
      start = 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
    start = 1'b1;
    cmd   = b;
    do @(posedge clk); while (busy);
    rsp_expected_q.push_back(table_apply(b));
  endtask

  task automatic test_empty_table();
    send_cmd(ACT_GET, 32'h0, 32'h0);
    send_cmd(ACT_DEL, 32'h0, 32'hffff_ffff);
    send_cmd(ACT_NOP, 32'hffff_ffff, 32'hffff_ffff);
    send_cmd(ACT_PUT, 32'h0, 32'hffff_ffff);
    send_cmd(ACT_PUT, 32'hffff_ffff, 32'h0);
    send_cmd(ACT_GET, 32'hffff_ffff, 32'hffff_ffff);
    send_cmd(ACT_PUT, 32'h0, 32'h5a5a_a5a5);
    // delete of the last slot
    send_cmd(ACT_DEL, 32'hffff_ffff, 32'h0);
  endtask

  task automatic test_full_table();
    for (int i = 1; i < TBL_DEPTH; i++)
      send_cmd(ACT_PUT, 32'h1000_0000 * i + i, $urandom);
    send_cmd(ACT_PUT, 32'h0bad_cafe, 32'h1234_5678);
    send_cmd(ACT_PUT, 32'h0, 32'h8000_0001);
    // first slot delete shifts every later pair down one slot
    send_cmd(ACT_DEL, 32'h0, 32'h0);
    send_cmd(ACT_GET, 32'h1000_0000 * (TBL_DEPTH - 1) + (TBL_DEPTH - 1), 32'h0);
  endtask

  task automatic run_random(input int n, input int put_w, input int del_w,
                            input int get_w);
    int          pick;
    logic [31:0] key;
    action_t     act;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < put_w) act = ACT_PUT;
      else if (pick < put_w + del_w) act = ACT_DEL;
      else if (pick < put_w + del_w + get_w) act = ACT_GET;
      else act = ACT_NOP;
      if ($urandom_range(0, 15) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      send_cmd(act, key, $urandom);
    end
  endtask

  task automatic test_random_mixed();
    run_random(300, 45, 20, 30);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    run_random(200, 40, 25, 30);
    idle_on = 1'b1;
  endtask

  task automatic test_drain();
    run_random(150, 25, 50, 20);
  endtask

  task automatic test_fill();
    run_random(150, 60, 10, 25);
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    tbl_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_full_table();
    test_random_mixed();
    test_back_to_back();
    test_drain();
    test_fill();

    @(negedge clk);
    start = 1'b0;
    while (rsp_expected_q.size() != 0) @(posedge clk);
    repeat (TBL_DEPTH + 4) @(posedge clk);

    if (mismatches == 0) begin
      $display("key_value_table_tb OK");
    end else begin
      $display("key_value_table_tb NOT OK");
    end
    $finish;
  end

endmodule
